// ===== rtl/mrq_pkg.sv =====
// package: types, constants and helpers of the multicast retransmit queue
package mrq_pkg;

   localparam int QueueDepth = 8;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int MaxBurst = 16;
   localparam int SlotW = 49;

   localparam logic [1:0] ReqAdd = 2'd0;
   localparam logic [1:0] ReqRemove = 2'd1;
   localparam logic [1:0] ReqTick = 2'd2;

   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StBusy = 2'd1;
   localparam logic [1:0] StNotFound = 2'd2;
   localparam logic [1:0] StNone = 2'd3;

   localparam logic [0:0] CsrInterval = 1'd0;
   localparam logic [0:0] CsrBurst = 1'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  msg_type;
      logic [15:0] msg_id;
      logic        msg_priority;
      logic [7:0]  transmissions;
      logic [15:0] payload_ref;
      logic [31:0] tick_count;
   } req_type_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [IdxW-1:0] slot_index;
      logic [7:0]      sent_type;
      logic [15:0]     sent_id;
      logic [15:0]     sent_payload_ref;
      logic [7:0]      sends_left;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  mtype;
      logic [15:0] id;
      logic        prio;
      logic [7:0]  count;
      logic [15:0] payload;
   } slot_type;

endpackage

// ===== rtl/mrq_ram.sv =====
// generic single-port-write, single-read ram with registered read data
module mrq_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ===== rtl/multicast_retransmit_queue.sv =====
// top level: slot table retransmit queue with add, remove and timed round-robin send
// One request at a time is handled by a sequencer around a slot memory
// (QueueDepth entries, registered read) plus per-slot live and priority flag
// registers. An add picks a free slot from the flags, searching backwards from
// the pointer, and writes it in the accept cycle. A remove reads every slot
// once. Every tick first runs a 32/16 bit serial remainder; a tick off the
// interval then answers. A processed tick runs, for each send, a pick from the
// flags, a read of the slot, and a write back of the decremented count with the
// result load, and then one final pick; when nothing is sent it answers with a
// single result. Time spent waiting on a held result comes on top. The next
// request is taken once the last result for the current one is handed to the
// output register. Reset clears the live flags at once; there is no clearing
// pass.
module multicast_retransmit_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mrq_pkg::req_type_type     req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mrq_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [15:0]               csr_wdata
);
   localparam int D = mrq_pkg::QueueDepth;
   localparam int IW = mrq_pkg::IdxW;

   typedef enum logic [2:0] {
      S_IDLE, S_REM_RD, S_DIV, S_PICK, S_SEND_RD, S_SEND_WR, S_OUT
   } state_type;

   state_type state_ff;
   mrq_pkg::req_type_type req_ff;
   mrq_pkg::rsp_type rsp_ff, rsp_in;
   mrq_pkg::rsp_type res_ff, res_in;
   logic rsp_valid_ff;
   logic [15:0] interval_ff;
   logic [4:0] burst_ff;
   logic [D-1:0] live_ff, prio_ff;
   logic [IW-1:0] next_ff, idx_ff;
   logic [IW:0] cnt_ff;
   logic [4:0] sent_ff;
   logic found_ff;
   logic [16:0] rem_ff;
   logic [5:0] dcnt_ff;

   // slot memory
   logic ram_we;
   logic [IW-1:0] ram_wa, ram_ra;
   mrq_pkg::slot_type ram_wd, ram_rd;
   mrq_ram #(.Width(mrq_pkg::SlotW), .Depth(D)) u_slots (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // free search backwards from the pointer
   logic free_hit;
   logic [IW-1:0] free_idx;
   always_comb begin
      logic [IW-1:0] k;
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = D - 1; i >= 0; i--) begin
         k = next_ff - IW'(i);
         if (!live_ff[k]) begin
            free_hit = 1'b1;
            free_idx = k;
         end
      end
   end

   // send pick forward from the pointer, priority first
   logic pick_hit, pp_hit;
   logic [IW-1:0] pick_idx, pp_idx, pa_idx;
   always_comb begin
      logic [IW-1:0] k;
      logic pa_hit;
      pp_hit = 1'b0; pa_hit = 1'b0; pp_idx = '0; pa_idx = '0;
      for (int i = D - 1; i >= 0; i--) begin
         k = next_ff + IW'(i);
         if (live_ff[k] && prio_ff[k]) begin pp_hit = 1'b1; pp_idx = k; end
         if (live_ff[k]) begin pa_hit = 1'b1; pa_idx = k; end
      end
      pick_hit = pa_hit;
      pick_idx = pp_hit ? pp_idx : pa_idx;
   end

   logic [15:0] iv;
   assign iv = (interval_ff == 16'd0) ? 16'd1 : interval_ff;
   logic [16:0] rem_sh, rem_sub;
   assign rem_sh = {rem_ff[15:0], req_ff.tick_count[5'd31 - dcnt_ff[4:0]]};
   assign rem_sub = rem_sh - {1'b0, iv};

   logic [4:0] burst_eff;
   assign burst_eff = (burst_ff > 5'(mrq_pkg::MaxBurst)) ? 5'(mrq_pkg::MaxBurst) : burst_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   logic [7:0] dec_count;
   assign dec_count = ram_rd.count - 8'd1;

   // memory port control
   always_comb begin
      ram_we = 1'b0;
      ram_wa = idx_ff;
      ram_wd = ram_rd;
      ram_ra = idx_ff;
      if (state_ff == S_IDLE && req_valid && req_data.req_type == mrq_pkg::ReqAdd
          && free_hit) begin
         ram_we = 1'b1;
         ram_wa = free_idx;
         ram_wd = '{mtype: req_data.msg_type, id: req_data.msg_id,
                    prio: req_data.msg_priority, count: req_data.transmissions,
                    payload: req_data.payload_ref};
      end else if (state_ff == S_REM_RD) begin
         ram_ra = cnt_ff[IW-1:0];
      end else if (state_ff == S_SEND_WR && out_free) begin
         ram_we = 1'b1;
         ram_wd.count = dec_count;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // pending result of the accepted request; add outcome is known at once
   always_comb begin
      res_in = '0;
      res_in.status = mrq_pkg::StNone;
      res_in.last = 1'b1;
      if (req_data.req_type == mrq_pkg::ReqAdd) begin
         if (free_hit) begin
            res_in.status = mrq_pkg::StOk;
            res_in.slot_index = free_idx;
         end else begin
            res_in.status = mrq_pkg::StBusy;
         end
      end
   end

   // a send is the last one when the burst is used up or no slot stays live
   logic [D-1:0] live_after;
   logic send_last;
   always_comb begin
      live_after = live_ff;
      if (dec_count == 8'd0) live_after[idx_ff] = 1'b0;
      send_last = (sent_ff + 5'd1 == burst_eff) || (live_after == '0);
   end

   // output register load: a send result or the pending single result
   logic rsp_load;
   assign rsp_load = out_free && (state_ff == S_OUT || state_ff == S_SEND_WR);
   always_comb begin
      if (state_ff == S_OUT) begin
         rsp_in = res_ff;
      end else begin
         rsp_in = '{status: mrq_pkg::StOk, slot_index: idx_ff,
            sent_type: ram_rd.mtype, sent_id: ram_rd.id,
            sent_payload_ref: ram_rd.payload, sends_left: dec_count,
            last: send_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         interval_ff <= 16'd1;
         burst_ff <= 5'd1;
         live_ff <= '0;
         prio_ff <= '0;
         next_ff <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (rsp_load) rsp_ff <= rsp_in;
         if (csr_we) begin
            case (csr_index)
               mrq_pkg::CsrInterval: interval_ff <= csr_wdata;
               mrq_pkg::CsrBurst: burst_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               res_ff <= res_in;
               case (req_data.req_type)
                  mrq_pkg::ReqAdd: begin
                     if (free_hit) begin
                        live_ff[free_idx] <= (req_data.transmissions != 8'd0);
                        prio_ff[free_idx] <= req_data.msg_priority;
                        next_ff <= free_idx;
                     end
                     state_ff <= S_OUT;
                  end
                  mrq_pkg::ReqRemove: begin
                     cnt_ff <= '0; found_ff <= 1'b0; state_ff <= S_REM_RD;
                  end
                  mrq_pkg::ReqTick: begin
                     rem_ff <= '0; dcnt_ff <= '0; sent_ff <= '0; state_ff <= S_DIV;
                  end
                  default: state_ff <= S_OUT;
               endcase
            end
            S_REM_RD: begin
               // compare the slot read last cycle
               if (cnt_ff != '0) begin
                  if (live_ff[idx_ff] && ram_rd.mtype == req_ff.msg_type
                      && ram_rd.id == req_ff.msg_id) begin
                     live_ff[idx_ff] <= 1'b0;
                     found_ff <= 1'b1;
                  end
               end
               idx_ff <= cnt_ff[IW-1:0];
               if (cnt_ff == (IW+1)'(D)) begin
                  res_ff.status <= (found_ff || (live_ff[idx_ff]
                     && ram_rd.mtype == req_ff.msg_type && ram_rd.id == req_ff.msg_id))
                     ? mrq_pkg::StOk : mrq_pkg::StNotFound;
                  state_ff <= S_OUT;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_DIV: begin
               // restoring remainder, one dividend bit a cycle
               rem_ff <= rem_sub[16] ? rem_sh : rem_sub;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 6'd31) begin
                  if ((rem_sub[16] ? rem_sh : rem_sub) == 17'd0) state_ff <= S_PICK;
                  else state_ff <= S_OUT;
               end
            end
            S_PICK: begin
               if (sent_ff == burst_eff || !pick_hit) begin
                  if (sent_ff == 5'd0) state_ff <= S_OUT;
                  else state_ff <= S_IDLE;
               end else begin
                  idx_ff <= pick_idx;
                  state_ff <= S_SEND_RD;
               end
            end
            S_SEND_RD: state_ff <= S_SEND_WR;
            S_SEND_WR: if (out_free) begin
               if (dec_count == 8'd0) live_ff[idx_ff] <= 1'b0;
               next_ff <= idx_ff + 1'b1;
               sent_ff <= sent_ff + 1'b1;
               state_ff <= S_PICK;
            end
            S_OUT: if (out_free) begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // a new request is never taken while a send burst is underway
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND_WR) |-> req_stall)
      else $error("request taken during send");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND_WR && out_free) |=> !live_ff[$past(idx_ff)] ||
      ($past(dec_count) != 8'd0))
      else $error("slot left live with zero count");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < 17'(iv)))
      else $error("remainder out of range");
   // a stalled result holds still
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
endmodule
